>>> design/cswd_pkg.sv
`default_nettype none

package cswd_pkg;

  localparam int unsigned CrcW      = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned HistDepth = 4;
  localparam int unsigned ShadowW   = 3;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned DigestW   = 64;
  localparam int unsigned OutDataW  = CrcW + DigestW;

  localparam logic [CrcW-1:0] PolyRst    = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] InitRst    = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] XorOutRst  = 32'hFFFF_FFFF;
  localparam logic [ShadowW-1:0] HistDepthCode = ShadowW'(HistDepth);

  typedef enum logic [CfgAddrW-1:0] {
    CFG_POLY        = 3'd0,
    CFG_INIT_VALUE  = 3'd1,
    CFG_XOR_OUT     = 3'd2,
    CFG_AUG_MODE    = 3'd3,
    CFG_SHADOW_SIZE = 3'd4
  } cfg_addr_e;

  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_ABSORB  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CrcW-1:0]    poly;
    logic [CrcW-1:0]    init_value;
    logic [CrcW-1:0]    xor_out;
    logic               augmented_mode;
    logic [ShadowW-1:0] shadow_size;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/cswd_cfg_regs.sv
`default_nettype none

module cswd_cfg_regs
  import cswd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CrcW-1:0]     cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_e'(cfg_addr_i))
        CFG_POLY:        cfg_d.poly           = cfg_wdata_i;
        CFG_INIT_VALUE:  cfg_d.init_value     = cfg_wdata_i;
        CFG_XOR_OUT:     cfg_d.xor_out        = cfg_wdata_i;
        CFG_AUG_MODE:    cfg_d.augmented_mode = cfg_wdata_i[0];
        CFG_SHADOW_SIZE: cfg_d.shadow_size    = cfg_wdata_i[ShadowW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly           <= PolyRst;
      cfg_q.init_value     <= InitRst;
      cfg_q.xor_out        <= XorOutRst;
      cfg_q.augmented_mode <= 1'b0;
      cfg_q.shadow_size    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/cswd_crc_next.sv
`default_nettype none

module cswd_crc_next
  import cswd_pkg::*;
(
  input  wire logic [CrcW-1:0]  poly_i,
  input  wire logic             aug_mode_i,
  input  wire logic [CrcW-1:0]  crc_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic      [CrcW-1:0]  crc_o
);

  logic [CrcW-1:0] direct_crc;
  logic [CrcW-1:0] aug_crc;

  // table form: entry for (top byte ^ data) built by eight shift steps
  always_comb begin
    logic [CrcW-1:0] r;
    r = {crc_i[CrcW-1 -: ByteW] ^ byte_i, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      r = r[CrcW-1] ? ({r[CrcW-2:0], 1'b0} ^ poly_i) : {r[CrcW-2:0], 1'b0};
    end
    direct_crc = r ^ {crc_i[CrcW-ByteW-1:0], {ByteW{1'b0}}};
  end

  // augmented form: data bits enter at the low end, msb first
  always_comb begin
    logic [CrcW-1:0] c;
    c = crc_i;
    for (int i = 0; i < ByteW; i++) begin
      c = {c[CrcW-2:0], byte_i[ByteW-1-i]} ^ (c[CrcW-1] ? poly_i : '0);
    end
    aug_crc = c;
  end

  assign crc_o = aug_mode_i ? aug_crc : direct_crc;

endmodule

`default_nettype wire

>>> design/crc32_with_shadow_digest_unit.sv
// MSB-first 32-bit CRC engine with a short digest of recent CRC top bytes.
//
// Input stream (s_axis): one beat per command. tuser carries cmd (restart or
// absorb), tdata[7:0] the data byte. A restart reloads init_value and clears
// the top-byte history; an absorb folds one byte into the CRC.
// Output stream (m_axis): exactly one beat per input beat, in order. tdata
// holds crc in bits 31:0 and the 64-bit digest in bits 95:32.
// Configuration: plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i), to be
// written only while no beats are in flight.
//
// Timing: an input register feeds the byte-wide CRC network, whose result is
// written to CRC state and output register in the same cycle, so a beat
// passes both registers to m_axis. One beat per clock is sustained while m_axis
// is ready; the limit is the eight-step XOR network feeding the CRC register.
// Stall: while an output beat waits, the input register still takes one
// beat; s_axis_tready_o drops only when both stages are full.
// Reset: CRC state takes the reset init value, history clears, config regs
// take their reset values and both stages empty.
`default_nettype none

module crc32_with_shadow_digest_unit
  import cswd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [ByteW-1:0]    s_axis_tdata_i,  // data_byte
  input  wire logic                s_axis_tuser_i,  // cmd
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [OutDataW-1:0] m_axis_tdata_o,  // crc, digest
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CrcW-1:0]     cfg_wdata_i
);

  cfg_t cfg;

  cswd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic             in_valid_q;
  cmd_e             in_cmd_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [CrcW-1:0] crc_q, crc_d, crc_next;
  logic [HistDepth-1:0][ByteW-1:0] hist_q, hist_d;
  logic [ShadowW-1:0] shown;
  logic [DigestW-1:0] digest_d;
  logic [CrcW-1:0] crc_out;
  logic stall, fire, s_acc;

  assign stall           = out_valid_q && !m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || !stall;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = in_valid_q && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
  end

  cswd_crc_next u_crc_next (
    .poly_i     (cfg.poly),
    .aug_mode_i (cfg.augmented_mode),
    .crc_i      (crc_q),
    .byte_i     (in_byte_q),
    .crc_o      (crc_next)
  );

  always_comb begin
    if (in_cmd_q == CMD_ABSORB) begin
      crc_d     = crc_next;
      hist_d[0] = crc_next[CrcW-1 -: ByteW];
      for (int k = 1; k < HistDepth; k++) begin
        hist_d[k] = hist_q[k-1];
      end
    end else begin
      crc_d  = cfg.init_value;
      hist_d = '0;
    end
  end

  // sizes above the history depth show the whole history
  assign shown   = (cfg.shadow_size > HistDepthCode) ? HistDepthCode : cfg.shadow_size;
  assign crc_out = crc_d ^ cfg.xor_out;

  always_comb begin
    digest_d = '0;
    digest_d[CrcW-1:0] = crc_out;
    for (int k = 0; k < HistDepth; k++) begin
      if (ShadowW'(k) < shown) begin
        digest_d[CrcW + ByteW*k +: ByteW] = hist_d[k];
      end
    end
    out_data_d = {digest_d, crc_out};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= InitRst;
      hist_q <= '0;
    end else if (fire) begin
      crc_q  <= crc_d;
      hist_q <= hist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

>>> design/cswd_checker.sv
`default_nettype none

module cswd_checker
  import cswd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  // a waiting output beat is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  // digest low word always repeats the crc
  a_digest_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[2*CrcW-1:CrcW] == m_axis_tdata_o[CrcW-1:0])
    else $error("digest low word differs from crc");

  // input side is held off only by output backpressure
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // an accepted beat reaches a free output via the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o ##1 !m_axis_tvalid_o
      |=> m_axis_tvalid_o)
    else $error("accepted beat did not reach output");

endmodule

bind crc32_with_shadow_digest_unit cswd_checker u_cswd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
